FILE: sv/vpt_pkg.sv
package vpt_pkg;

   localparam int ADDR_W     = 14;
   localparam int VRAM_DEPTH = 16384;

   typedef enum logic [2:0] {
      K_CTRL_WR = 3'd0,
      K_CTRL_RD = 3'd1,
      K_DATA_RD = 3'd2,
      K_DATA_WR = 3'd3,
      K_TICK    = 3'd4,
      K_H_RD    = 3'd5,
      K_V_RD    = 3'd6,
      K_NOP     = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      CODE_VRAM_RD = 2'd0,
      CODE_VRAM_WR = 2'd1,
      CODE_REG_WR  = 2'd2,
      CODE_CRAM_WR = 2'd3
   } cmd_code_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_FILL,
      BK_DIVIDE
   } back_state_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data;
   } entry_type;

   typedef struct packed {
      logic done;
      logic zero;
   } rem_stat_type;

   localparam logic [3:0] REG_MODE0    = 4'd0;
   localparam logic [3:0] REG_MODE1    = 4'd1;
   localparam logic [3:0] REG_LINE_CNT = 4'd10;

   localparam logic [1:0] VARIANT_PAL = 2'd1;

   localparam logic [8:0] DOT_WRAP    = 9'd342;
   localparam logic [8:0] DOT_EVENT   = 9'd256;
   localparam logic [8:0] LINES_NTSC  = 9'd262;
   localparam logic [8:0] LINES_PAL   = 9'd313;

   localparam logic [8:0] HEIGHT_SMALL = 9'd192;
   localparam logic [8:0] HEIGHT_MID   = 9'd224;
   localparam logic [8:0] HEIGHT_LARGE = 9'd240;

   localparam logic [8:0] V_NTSC_SMALL = 9'h0DB;
   localparam logic [8:0] V_NTSC_MID   = 9'h0EB;
   localparam logic [8:0] V_NTSC_SHIFT = 9'h006;
   localparam logic [8:0] V_PAL_SMALL  = 9'h0F3;
   localparam logic [8:0] V_PAL_MID    = 9'h103;
   localparam logic [8:0] V_PAL_LARGE  = 9'h10B;
   localparam logic [8:0] V_PAL_SHIFT  = 9'h039;

endpackage

FILE: sv/vpt_front.sv
module vpt_front
   import vpt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept_en,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic [2:0] req_tuser,
   output logic       q_valid,
   output entry_type  q_entry,
   input  logic       q_pop
);

   entry_type  slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   entry_type  new_entry;

   assign req_tready = accept_en && (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != 2'd0);
   assign q_entry    = slot_ff[rd_ptr_ff];

   // classify: keep the bus byte only for the two write kinds
   always_comb begin
      new_entry.kind = kind_type'(req_tuser);
      case (new_entry.kind)
         K_CTRL_WR, K_DATA_WR: new_entry.data = req_tdata;
         default:              new_entry.data = 8'd0;
      endcase
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

FILE: sv/vpt_rem.sv
module vpt_rem
   import vpt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [7:0]   dividend,
   input  logic [7:0]   divisor,
   output rem_stat_type stat
);

   logic       busy_ff, busy_in;
   logic       done_ff, done_in;
   logic [2:0] step_ff, step_in;
   logic [7:0] rem_ff, rem_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] div_ff, div_in;
   logic [8:0] trial;

   assign stat.done = done_ff;
   assign stat.zero = (rem_ff == 8'd0);

   // one restoring step per cycle, eight steps per check
   always_comb begin
      trial    = {rem_ff, shift_ff[7]};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      rem_in   = rem_ff;
      shift_in = shift_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         step_in  = 3'd0;
         rem_in   = 8'd0;
         shift_in = dividend;
         div_in   = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = 8'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[7:0];
         end
         shift_in = {shift_ff[6:0], 1'b0};
         step_in  = step_ff + 3'd1;
         if (step_ff == 3'd7) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
      div_ff   <= div_in;
   end

endmodule

FILE: sv/vpt_back.sv
module vpt_back
   import vpt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_valid,
   input  logic [1:0]   csr_data,
   input  logic         q_valid,
   input  entry_type    q_entry,
   output logic         q_pop,
   output logic         accept_en,
   output logic         rem_start,
   output logic [7:0]   rem_dividend,
   output logic [7:0]   rem_divisor,
   input  rem_stat_type rem_stat,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [15:0]  rsp_tdata
);

   back_state_type    state_ff, state_in;
   logic              second_ff, second_in;
   logic [15:0]       cmd_ff, cmd_in;
   logic [7:0]        pre_ff, pre_in;
   logic [7:0]        mode0_ff, mode0_in;
   logic [7:0]        mode1_ff, mode1_in;
   logic [7:0]        lcnt_ff, lcnt_in;
   logic              stat7_ff, stat7_in;
   logic              frame_req_ff, frame_req_in;
   logic              line_req_ff, line_req_in;
   logic [8:0]        dot_ff, dot_in;
   logic [8:0]        line_ff, line_in;
   logic [1:0]        variant_ff, variant_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       rsp_data_ff, rsp_data_in;

   logic [7:0]        vram [VRAM_DEPTH];
   logic [7:0]        rdata_ff;
   logic              vram_we;
   logic [ADDR_W-1:0] vram_waddr, vram_raddr;
   logic [7:0]        vram_wdata;

   logic              is_pal, slot_free, emit, wrap_out;
   logic [7:0]        rv, remap;
   logic [ADDR_W-1:0] addr, second_addr;
   logic [8:0]        height, limit, dot_inc, dot_n, line_inc, line_n;
   logic              wrap, at_event, frame_hit, line_chk;

   assign is_pal       = (variant_ff == VARIANT_PAL);
   assign slot_free    = !rsp_valid_ff || rsp_tready;
   assign addr         = cmd_ff[ADDR_W-1:0];
   assign second_addr  = {q_entry.data[5:0], cmd_ff[7:0]};
   assign accept_en    = (state_ff != BK_CLEAR);
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rem_dividend = line_n[7:0];
   assign rem_divisor  = lcnt_ff;

   always_comb begin
      if (mode1_ff[3]) begin
         height = HEIGHT_LARGE;
      end else if (mode1_ff[4]) begin
         height = HEIGHT_MID;
      end else begin
         height = HEIGHT_SMALL;
      end
   end

   // counter read remap per console and active height
   always_comb begin
      remap = line_ff[7:0];
      if (!is_pal) begin
         if (height == HEIGHT_SMALL) begin
            if (line_ff >= V_NTSC_SMALL) remap = 8'(line_ff - V_NTSC_SHIFT);
         end else if (height == HEIGHT_MID) begin
            if (line_ff >= V_NTSC_MID) remap = 8'(line_ff - V_NTSC_SHIFT);
         end
      end else begin
         if (height == HEIGHT_SMALL) begin
            if (line_ff >= V_PAL_SMALL) remap = 8'(line_ff - V_PAL_SHIFT);
         end else if (height == HEIGHT_MID) begin
            if (line_ff >= V_PAL_MID) remap = 8'(line_ff - V_PAL_SHIFT);
         end else begin
            if (line_ff >= V_PAL_LARGE) remap = 8'(line_ff - V_PAL_SHIFT);
         end
      end
   end

   // next counter values for a tick
   always_comb begin
      limit   = is_pal ? LINES_PAL : LINES_NTSC;
      dot_inc = dot_ff + 9'd1;
      if (dot_inc >= DOT_WRAP) begin
         dot_n    = 9'd0;
         line_inc = line_ff + 9'd1;
      end else begin
         dot_n    = dot_inc;
         line_inc = line_ff;
      end
      wrap      = (line_inc >= limit);
      line_n    = wrap ? 9'd0 : line_inc;
      at_event  = (dot_n == DOT_EVENT);
      frame_hit = at_event && (line_n == height - 9'd1);
      line_chk  = at_event && mode0_ff[4] && (lcnt_ff != 8'd0) &&
                  (line_n != 9'd0) && (line_n < height);
   end

   always_comb begin
      state_in     = state_ff;
      second_in    = second_ff;
      cmd_in       = cmd_ff;
      pre_in       = pre_ff;
      mode0_in     = mode0_ff;
      mode1_in     = mode1_ff;
      lcnt_in      = lcnt_ff;
      stat7_in     = stat7_ff;
      frame_req_in = frame_req_ff;
      line_req_in  = line_req_ff;
      dot_in       = dot_ff;
      line_in      = line_ff;
      variant_in   = csr_valid ? csr_data : variant_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      vram_we      = 1'b0;
      vram_waddr   = addr;
      vram_wdata   = q_entry.data;
      vram_raddr   = addr;
      q_pop        = 1'b0;
      rem_start    = 1'b0;
      emit         = 1'b0;
      rv           = 8'd0;
      wrap_out     = 1'b0;

      case (state_ff)
         BK_CLEAR: begin
            vram_we    = 1'b1;
            vram_waddr = clr_ff;
            vram_wdata = 8'd0;
            clr_in     = clr_ff + ADDR_W'(1);
            if (&clr_ff) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (q_valid && slot_free) begin
               q_pop = 1'b1;
               emit  = 1'b1;
               case (q_entry.kind)
                  K_CTRL_WR: begin
                     if (!second_ff) begin
                        cmd_in    = {cmd_ff[15:8], q_entry.data};
                        second_in = 1'b1;
                     end else begin
                        cmd_in    = {q_entry.data, cmd_ff[7:0]};
                        second_in = 1'b0;
                        case (cmd_code_type'(q_entry.data[7:6]))
                           CODE_VRAM_RD: begin
                              vram_raddr = second_addr;
                              cmd_in     = {q_entry.data[7:6], second_addr + ADDR_W'(1)};
                              state_in   = BK_FILL;
                           end
                           CODE_VRAM_WR: begin
                              vram_raddr = second_addr;
                              state_in   = BK_FILL;
                           end
                           CODE_REG_WR: begin
                              case (q_entry.data[3:0])
                                 REG_MODE0:    mode0_in = cmd_ff[7:0];
                                 REG_MODE1:    mode1_in = cmd_ff[7:0];
                                 REG_LINE_CNT: lcnt_in  = cmd_ff[7:0];
                                 default:      ;
                              endcase
                           end
                           default: ;
                        endcase
                     end
                  end
                  K_CTRL_RD: begin
                     second_in    = 1'b0;
                     frame_req_in = 1'b0;
                     line_req_in  = 1'b0;
                     rv           = {stat7_ff, 7'd0};
                     stat7_in     = 1'b0;
                  end
                  K_DATA_RD: begin
                     second_in = 1'b0;
                     rv        = pre_ff;
                     cmd_in    = {cmd_ff[15:14], addr + ADDR_W'(1)};
                     state_in  = BK_FILL;
                  end
                  K_DATA_WR: begin
                     second_in = 1'b0;
                     // palette writes have no read path here: drop them
                     if (cmd_code_type'(cmd_ff[15:14]) != CODE_CRAM_WR) begin
                        vram_we = 1'b1;
                        pre_in  = q_entry.data;
                     end
                     cmd_in = {cmd_ff[15:14], addr + ADDR_W'(1)};
                  end
                  K_TICK: begin
                     dot_in   = dot_n;
                     line_in  = line_n;
                     wrap_out = wrap;
                     if (frame_hit) begin
                        stat7_in = 1'b1;
                        if (mode1_ff[5]) frame_req_in = 1'b1;
                     end
                     if (line_chk) begin
                        // hold the result until the remainder check is done
                        emit      = 1'b0;
                        rem_start = 1'b1;
                        state_in  = BK_DIVIDE;
                     end
                  end
                  K_H_RD:  rv = dot_ff[8:1];
                  K_V_RD:  rv = remap;
                  default: ;
               endcase
            end
         end
         BK_FILL: begin
            pre_in   = rdata_ff;
            state_in = BK_IDLE;
         end
         BK_DIVIDE: begin
            if (rem_stat.done) begin
               if (rem_stat.zero) line_req_in = 1'b1;
               emit     = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'd0, wrap_out,
                         (frame_req_in && mode1_in[5]) || (line_req_in && mode0_in[4]),
                         rv};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         second_ff    <= 1'b0;
         cmd_ff       <= 16'd0;
         pre_ff       <= 8'd0;
         mode0_ff     <= 8'hFF;
         mode1_ff     <= 8'hFF;
         lcnt_ff      <= 8'hFF;
         stat7_ff     <= 1'b0;
         frame_req_ff <= 1'b0;
         line_req_ff  <= 1'b0;
         dot_ff       <= 9'd0;
         line_ff      <= 9'd0;
         variant_ff   <= 2'd0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         second_ff    <= second_in;
         cmd_ff       <= cmd_in;
         pre_ff       <= pre_in;
         mode0_ff     <= mode0_in;
         mode1_ff     <= mode1_in;
         lcnt_ff      <= lcnt_in;
         stat7_ff     <= stat7_in;
         frame_req_ff <= frame_req_in;
         line_req_ff  <= line_req_in;
         dot_ff       <= dot_in;
         line_ff      <= line_in;
         variant_ff   <= variant_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (vram_we) begin
         vram[vram_waddr] <= vram_wdata;
      end
      rdata_ff <= vram[vram_raddr];
   end

endmodule

FILE: sv/video_processor_ports_and_timing.sv
// Channel   Direction  Transaction carries
// req_*     in         tuser[2:0] kind, tdata[7:0] bus byte
// rsp_*     out        tdata[7:0] read value, [8] irq pending, [9] frame wrapped
// csr_*     in         data[1:0] machine variant
//
// Items pass a two-entry queue, then the execution side; data reads and second
// control bytes that load the read buffer then pass a fill state (memory read, then load).
// A tick at dot 256 of an active line with line interrupts enabled waits while
// the 8-step serial remainder unit checks the line counter reload.
// Reset is synchronous; afterwards a clearing pass zeroes all 16384 video memory
// bytes with req_tready low. A stalled result holds the execution side only.
module video_processor_ports_and_timing
   import vpt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] bus_byte
   input  logic [2:0]  req_tuser,   // [2:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] read_value, [8] irq_pending, [9] frame_wrapped
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_data
);

   logic         accept_en;
   logic         q_valid;
   entry_type    q_entry;
   logic         q_pop;
   logic         rem_start;
   logic [7:0]   rem_dividend;
   logic [7:0]   rem_divisor;
   rem_stat_type rem_stat;

   assign csr_ready = 1'b1;

   vpt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept_en  (accept_en),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop)
   );

   vpt_rem u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (rem_dividend),
      .divisor  (rem_divisor),
      .stat     (rem_stat)
   );

   vpt_back u_back (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_data     (csr_data),
      .q_valid      (q_valid),
      .q_entry      (q_entry),
      .q_pop        (q_pop),
      .accept_en    (accept_en),
      .rem_start    (rem_start),
      .rem_dividend (rem_dividend),
      .rem_divisor  (rem_divisor),
      .rem_stat     (rem_stat),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !req_tready)
      else $error("input taken during memory clearing pass");

   a_wrap_no_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[9]) |-> (rsp_tdata[7:0] == 8'd0))
      else $error("frame wrap reported with a read value");

   a_divide_no_pop: assert property (@(posedge clock) disable iff (reset)
      rem_stat.done |-> !q_pop)
      else $error("new item started while a tick was still finishing");

endmodule

FILE: test/tb_video_processor_ports_and_timing.sv
module tb_video_processor_ports_and_timing;
   import vpt_pkg::*;

   localparam int CRAM_DEPTH = 64;
   localparam int HOLD_LEN   = 300;

   localparam logic [1:0] VARIANT_NTSC     = 2'd0;
   localparam logic [1:0] VARIANT_HANDHELD = 2'd2;
   localparam logic [1:0] VARIANT_SPARE    = 2'd3;

   typedef struct packed {
      logic       frame_wrapped;
      logic       irq_pending;
      logic [7:0] read_value;
   } port_result_type;

   typedef struct packed {
      kind_type        kind;
      logic [7:0]      data;
      logic            typed;
      port_result_type want;
   } access_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // [7:0] bus_byte
   logic [2:0]  req_tuser = 3'd0;   // [2:0] kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;          // [7:0] read_value, [8] irq_pending, [9] frame_wrapped
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_data = 2'd0;

   // predicted block state
   logic [1:0]  variant;
   logic        second_due;
   logic [15:0] cmd_word;
   logic [7:0]  read_ahead;
   logic [7:0]  mode_reg [16];
   logic [7:0]  status_flags;
   logic        frame_req;
   logic        line_req;
   logic [8:0]  dot_ctr;
   logic [8:0]  line_ctr;
   logic [7:0]  vram [VRAM_DEPTH];
   logic [7:0]  cram [CRAM_DEPTH];

   port_result_type expected_responses [$];
   access_row_type  directed_rows [$];

   int mismatches = 0;
   int sender_idle_pct = 0;
   int stall_pct = 0;
   int hold_requests = 0;
   int hold_seen = 0;
   int hold_left = 0;

   video_processor_ports_and_timing dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   task automatic flag_mismatch(input string what, input int got, input int want);
      $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
      mismatches++;
   endtask

   task automatic clear_model();
      variant      = VARIANT_NTSC;
      second_due   = 1'b0;
      cmd_word     = 16'd0;
      read_ahead   = 8'd0;
      status_flags = 8'd0;
      frame_req    = 1'b0;
      line_req     = 1'b0;
      dot_ctr      = 9'd0;
      line_ctr     = 9'd0;
      foreach (mode_reg[i]) mode_reg[i] = 8'hFF;
      foreach (vram[i]) vram[i] = 8'd0;
      foreach (cram[i]) cram[i] = 8'd0;
   endtask

   function automatic logic [8:0] active_height();
      if (mode_reg[REG_MODE1][3]) return HEIGHT_LARGE;
      if (mode_reg[REG_MODE1][4]) return HEIGHT_MID;
      return HEIGHT_SMALL;
   endfunction

   function automatic logic [7:0] remap_line();
      int v;
      int h;
      v = line_ctr;
      h = active_height();
      if (variant != VARIANT_PAL) begin
         if (h == HEIGHT_SMALL) return 8'((v >= 'hDB) ? 'hD5 + v - 'hDB : v);
         if (h == HEIGHT_MID) return 8'((v >= 'hEB) ? 'hE5 + v - 'hEB : v);
         return 8'((v >= 'h100) ? v - 'h100 : v);
      end
      if (h == HEIGHT_SMALL) return 8'((v >= 'hF3) ? 'hBA + v - 'hF3 : v);
      if (h == HEIGHT_MID) begin
         if (v >= 'h103) return 8'('hCA + v - 'h103);
         return 8'((v >= 'h100) ? v - 'h100 : v);
      end
      if (v >= 'h10B) return 8'('hD2 + v - 'h10B);
      return 8'((v >= 'h100) ? v - 'h100 : v);
   endfunction

   // enables are taken before the counters move
   function automatic logic advance_counters();
      logic wrapped;
      logic line_en;
      logic frame_en;
      int   limit;
      int   height;
      int   r;
      wrapped  = 1'b0;
      line_en  = mode_reg[REG_MODE0][4];
      frame_en = mode_reg[REG_MODE1][5];
      limit    = (variant == VARIANT_PAL) ? LINES_PAL : LINES_NTSC;
      dot_ctr  = dot_ctr + 9'd1;
      if (dot_ctr >= DOT_WRAP) begin
         dot_ctr  = 9'd0;
         line_ctr = line_ctr + 9'd1;
      end
      if (line_ctr >= limit) begin
         wrapped  = 1'b1;
         line_ctr = 9'd0;
      end
      height = active_height();
      if (line_ctr == height - 1 && dot_ctr == DOT_EVENT) begin
         status_flags[7] = 1'b1;
         if (frame_en) frame_req = 1'b1;
      end
      r = mode_reg[REG_LINE_CNT];
      if (r > 0 && line_ctr > 0 && line_ctr % r == 0 && line_ctr < height &&
          dot_ctr == DOT_EVENT && line_en)
         line_req = 1'b1;
      return wrapped;
   endfunction

   function automatic port_result_type predict_access(input kind_type k, input logic [7:0] b);
      port_result_type res;
      res = '0;
      case (k)
         K_CTRL_WR: begin
            if (!second_due) begin
               cmd_word[7:0] = b;
               second_due    = 1'b1;
            end else begin
               cmd_word[15:8] = b;
               second_due     = 1'b0;
               case (cmd_code_type'(cmd_word[15:14]))
                  CODE_VRAM_RD: begin
                     read_ahead      = vram[cmd_word[13:0]];
                     cmd_word[13:0] = cmd_word[13:0] + 14'd1;
                  end
                  CODE_VRAM_WR: read_ahead = vram[cmd_word[13:0]];
                  CODE_REG_WR:  mode_reg[cmd_word[11:8]] = cmd_word[7:0];
                  default: ;
               endcase
            end
         end
         K_CTRL_RD: begin
            second_due     = 1'b0;
            frame_req      = 1'b0;
            line_req       = 1'b0;
            res.read_value = status_flags;
            status_flags   = 8'd0;
         end
         K_DATA_RD: begin
            second_due     = 1'b0;
            res.read_value = read_ahead;
            read_ahead     = vram[cmd_word[13:0]];
            cmd_word[13:0] = cmd_word[13:0] + 14'd1;
         end
         K_DATA_WR: begin
            second_due = 1'b0;
            if (cmd_code_type'(cmd_word[15:14]) == CODE_CRAM_WR) begin
               cram[cmd_word[13:0] % CRAM_DEPTH] = b;
            end else begin
               vram[cmd_word[13:0]] = b;
               read_ahead           = b;
            end
            cmd_word[13:0] = cmd_word[13:0] + 14'd1;
         end
         K_TICK:  res.frame_wrapped = advance_counters();
         K_H_RD:  res.read_value = dot_ctr[8:1];
         K_V_RD:  res.read_value = remap_line();
         default: ;
      endcase
      res.irq_pending = (frame_req && mode_reg[REG_MODE1][5]) ||
                        (line_req && mode_reg[REG_MODE0][4]);
      return res;
   endfunction

   // hold valid low from the next falling edge on
   task automatic release_request();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic offer(input kind_type k, input logic [7:0] b, input logic typed,
                        input port_result_type typed_want,
                        output port_result_type predicted);
      int gap;
      gap = 0;
      while (gap < 60 && $urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= k;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      predicted = predict_access(k, b);
      expected_responses.push_back(typed ? typed_want : predicted);
   endtask

   task automatic send(input kind_type k, input logic [7:0] b);
      port_result_type r;
      offer(k, b, 1'b0, '0, r);
   endtask

   // the variant may only change with the block drained
   task automatic write_variant(input logic [1:0] v);
      release_request();
      while (expected_responses.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      variant = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic access_row_type row(input kind_type k, input logic [7:0] b,
                                          input logic typed, input logic [7:0] rv = 8'd0);
      access_row_type r;
      r.kind = k;
      r.data = b;
      r.typed = typed;
      r.want = '0;
      r.want.read_value = rv;
      return r;
   endfunction

   task automatic random_traffic(input int count);
      int           sent;
      int           pick;
      cmd_code_type code;
      logic         near;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (pick < 28) begin
            send(K_TICK, 8'($urandom));
            sent++;
         end else if (pick < 44) begin
            code = cmd_code_type'($urandom_range(3));
            near = ($urandom_range(9) < 6);
            if (code == CODE_REG_WR) begin
               send(K_CTRL_WR, 8'($urandom));
               send(K_CTRL_WR, {code, 6'($urandom)});
            end else begin
               send(K_CTRL_WR, near ? 8'($urandom_range(15)) : 8'($urandom));
               send(K_CTRL_WR, {code, near ? 6'd0 : 6'($urandom)});
            end
            sent += 2;
         end else if (pick < 58) begin
            send(K_DATA_WR, 8'($urandom));
            sent++;
         end else if (pick < 72) begin
            send(K_DATA_RD, 8'($urandom));
            sent++;
         end else if (pick < 79) begin
            send(K_CTRL_RD, 8'($urandom));
            sent++;
         end else if (pick < 85) begin
            send(K_H_RD, 8'($urandom));
            sent++;
         end else if (pick < 91) begin
            send(K_V_RD, 8'($urandom));
            sent++;
         end else if (pick < 96) begin
            // lone first byte: leaves the command half written
            send(K_CTRL_WR, 8'($urandom));
            sent++;
         end else begin
            send(K_NOP, 8'($urandom));
         end
      end
   endtask

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_seen != hold_requests) begin
         hold_seen  <= hold_requests;
         hold_left  <= HOLD_LEN;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin : check_response
      port_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_responses.size() == 0) begin
            flag_mismatch("response with nothing pending", rsp_tdata, 0);
         end else begin
            want = expected_responses.pop_front();
            if (rsp_tdata[7:0] != want.read_value)
               flag_mismatch("read_value", rsp_tdata[7:0], want.read_value);
            if (rsp_tdata[8] != want.irq_pending)
               flag_mismatch("irq_pending", rsp_tdata[8], want.irq_pending);
            if (rsp_tdata[9] != want.frame_wrapped)
               flag_mismatch("frame_wrapped", rsp_tdata[9], want.frame_wrapped);
         end
      end
   end

   initial begin
      #20000000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      port_result_type r;
      clear_model();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_variant(VARIANT_NTSC);

      directed_rows.push_back(row(K_CTRL_RD, 8'h00, 1'b1));
      directed_rows.push_back(row(K_DATA_RD, 8'h00, 1'b1));
      directed_rows.push_back(row(K_H_RD,    8'h00, 1'b1));
      directed_rows.push_back(row(K_V_RD,    8'h00, 1'b1));
      directed_rows.push_back(row(K_NOP,     8'hFF, 1'b1));
      directed_rows.push_back(row(K_TICK,    8'h5A, 1'b1));
      directed_rows.push_back(row(K_H_RD,    8'h00, 1'b1));
      // address 0x3FFF, read code: wraps to zero on the prefetch
      directed_rows.push_back(row(K_CTRL_WR, 8'hFF, 1'b1));
      directed_rows.push_back(row(K_CTRL_WR, 8'h3F, 1'b1));
      directed_rows.push_back(row(K_DATA_WR, 8'hFF, 1'b1));
      directed_rows.push_back(row(K_DATA_WR, 8'h00, 1'b1));
      directed_rows.push_back(row(K_CTRL_WR, 8'h00, 1'b0));
      directed_rows.push_back(row(K_CTRL_WR, 8'h40, 1'b0));
      directed_rows.push_back(row(K_DATA_RD, 8'hC3, 1'b0));
      directed_rows.push_back(row(K_DATA_RD, 8'h3C, 1'b0));
      directed_rows.push_back(row(K_CTRL_WR, 8'h00, 1'b0));
      directed_rows.push_back(row(K_CTRL_WR, 8'h80, 1'b0));
      // colour code: second byte latches only, then a write at 0x3FFF
      directed_rows.push_back(row(K_CTRL_WR, 8'hFF, 1'b0));
      directed_rows.push_back(row(K_CTRL_WR, 8'hFF, 1'b0));
      directed_rows.push_back(row(K_DATA_WR, 8'hAA, 1'b0));
      // control read drops a half-written command
      directed_rows.push_back(row(K_CTRL_WR, 8'h12, 1'b0));
      directed_rows.push_back(row(K_CTRL_RD, 8'h00, 1'b0));
      directed_rows.push_back(row(K_CTRL_WR, 8'h34, 1'b0));
      directed_rows.push_back(row(K_CTRL_WR, 8'h8A, 1'b0));
      directed_rows.push_back(row(K_V_RD,    8'h00, 1'b0));
      foreach (directed_rows[i])
         offer(directed_rows[i].kind, directed_rows[i].data, directed_rows[i].typed,
               directed_rows[i].want, r);

      write_variant(VARIANT_HANDHELD);
      hold_requests++;
      random_traffic(300);

      write_variant(VARIANT_PAL);
      sender_idle_pct = 84;
      random_traffic(250);

      write_variant(VARIANT_SPARE);
      sender_idle_pct = 0;
      stall_pct       = 84;
      random_traffic(300);

      write_variant(VARIANT_NTSC);
      sender_idle_pct = 17;
      stall_pct       = 17;
      random_traffic(300);

      release_request();
      for (int n = 0; n < 200000 && expected_responses.size() != 0; n++) @(posedge clock);
      repeat (40) @(posedge clock);
      if (expected_responses.size() != 0)
         flag_mismatch("responses never arrived", expected_responses.size(), 0);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/vpt_pkg.sv
sv/vpt_front.sv
sv/vpt_rem.sv
sv/vpt_back.sv
sv/video_processor_ports_and_timing.sv
test/tb_video_processor_ports_and_timing.sv
